/* rtl/core/itrn_pkg.sv */
// ----------------------------------------------------------------------------
// itrn_pkg: shared types and tables for the Roman numeral converter
// Holds the greedy term table (weights and letters) and the result struct
// of the shared compare/subtract unit.
// ----------------------------------------------------------------------------
package itrn_pkg;

  // Widths of the number being converted and of one ASCII letter.
  localparam int unsigned ValueWidth = 12;
  localparam int unsigned CharWidth  = 8;

  // Greedy table has thirteen terms, from 1000 down to 1.
  localparam int unsigned TermWidth = 4;
  localparam logic [TermWidth-1:0] LastTerm = 4'd12;

  // Largest number that has a standard numeral.
  localparam logic [ValueWidth-1:0] MaxValue = 12'd3999;

  // Letters as ASCII codes.
  localparam logic [CharWidth-1:0] ChM = 8'h4D;
  localparam logic [CharWidth-1:0] ChD = 8'h44;
  localparam logic [CharWidth-1:0] ChC = 8'h43;
  localparam logic [CharWidth-1:0] ChL = 8'h4C;
  localparam logic [CharWidth-1:0] ChX = 8'h58;
  localparam logic [CharWidth-1:0] ChV = 8'h56;
  localparam logic [CharWidth-1:0] ChI = 8'h49;

  // Result of one pass through the compare/subtract unit.
  typedef struct packed {
    logic                  hit;         // remainder covers the term weight
    logic [ValueWidth-1:0] diff;        // remainder minus the term weight
    logic                  has_second;  // term is a subtractive pair
    logic [CharWidth-1:0]  first;       // first letter of the term
    logic [CharWidth-1:0]  second;      // second letter of a pair
  } step_t;

  // Weight of each term.
  function automatic logic [ValueWidth-1:0] term_weight(input logic [TermWidth-1:0] t);
    logic [ValueWidth-1:0] w;
    case (t)
      4'd0:    w = 12'd1000;
      4'd1:    w = 12'd900;
      4'd2:    w = 12'd500;
      4'd3:    w = 12'd400;
      4'd4:    w = 12'd100;
      4'd5:    w = 12'd90;
      4'd6:    w = 12'd50;
      4'd7:    w = 12'd40;
      4'd8:    w = 12'd10;
      4'd9:    w = 12'd9;
      4'd10:   w = 12'd5;
      4'd11:   w = 12'd4;
      default: w = 12'd1;
    endcase
    return w;
  endfunction

  // First letter of each term.
  function automatic logic [CharWidth-1:0] term_first(input logic [TermWidth-1:0] t);
    logic [CharWidth-1:0] c;
    case (t)
      4'd0:    c = ChM;
      4'd1:    c = ChC;
      4'd2:    c = ChD;
      4'd3:    c = ChC;
      4'd4:    c = ChC;
      4'd5:    c = ChX;
      4'd6:    c = ChL;
      4'd7:    c = ChX;
      4'd8:    c = ChX;
      4'd9:    c = ChI;
      4'd10:   c = ChV;
      default: c = ChI;
    endcase
    return c;
  endfunction

  // Second letter of each subtractive pair.
  function automatic logic [CharWidth-1:0] term_second(input logic [TermWidth-1:0] t);
    logic [CharWidth-1:0] c;
    case (t)
      4'd1:    c = ChM;
      4'd3:    c = ChD;
      4'd5:    c = ChC;
      4'd7:    c = ChL;
      4'd9:    c = ChX;
      4'd11:   c = ChV;
      default: c = '0;
    endcase
    return c;
  endfunction

  // Odd terms below twelve are the subtractive pairs.
  function automatic logic term_is_pair(input logic [TermWidth-1:0] t);
    return t[0] && (t != 4'd13) && (t < LastTerm);
  endfunction

endpackage

/* rtl/core/itrn_step_unit.sv */
// ----------------------------------------------------------------------------
// itrn_step_unit: shared compare/subtract unit
// Compares the remainder with the weight of the current term, forms the
// difference and looks up the letters of that term.
// ----------------------------------------------------------------------------
module itrn_step_unit (
  input  logic [itrn_pkg::TermWidth-1:0]  term_i,
  input  logic [itrn_pkg::ValueWidth-1:0] rest_i,
  output itrn_pkg::step_t                 res_o
);
  import itrn_pkg::*;

  logic [ValueWidth-1:0] weight;

  // One compare and one subtract against the table weight.
  always_comb begin
    weight           = term_weight(term_i);
    res_o.hit        = (rest_i >= weight);
    res_o.diff       = rest_i - weight;
    res_o.has_second = term_is_pair(term_i);
    res_o.first      = term_first(term_i);
    res_o.second     = term_second(term_i);
  end

endmodule

/* rtl/core/integer_to_roman_numeral.sv */
// ----------------------------------------------------------------------------
// integer_to_roman_numeral: number to Roman numeral letter stream
// Converts a number from 1 to 3999 into its standard Roman numeral, one
// ASCII letter per output word, with tlast on the final letter.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one number per word in s_axis_tdata[11:0].
//   A word is taken only while the converter is idle. A zero or a number
//   above 3999 is taken and dropped without any output.
//   The output stream gives the letters most significant first; each word
//   holds one ASCII letter in m_axis_tdata[7:0], and m_axis_tlast marks the
//   last letter of the numeral.
// Sequencing:
//   A sequencer walks the thirteen-term greedy table through one shared
//   compare/subtract unit, loading the letters of a number (1 to 15) one
//   after another and passing over up to 12 terms; no new number is taken
//   until the last letter of the current one has been loaded.
//   The next number is taken in the cycle after the last letter is loaded
//   into the output register, even while that letter still waits.
// Reset and stalls:
//   Reset returns the converter to idle with the output register empty.
//   While the receiver holds tready low, the output word holds and the
//   sequencer waits; table moves that emit nothing still proceed.
// ----------------------------------------------------------------------------
module integer_to_roman_numeral (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream; tdata fields from bit 0: value[11:0], zero padding.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  // Output stream; tdata fields from bit 0: symbol[7:0].
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast
);
  import itrn_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StBusy = 1'b1;

  logic                  state_q, state_d;
  logic [TermWidth-1:0]  term_q, term_d;
  logic [ValueWidth-1:0] rest_q, rest_d;
  logic                  pend_q, pend_d;
  logic                  ovalid_q, ovalid_d;
  logic [CharWidth-1:0]  sym_q, sym_d;
  logic                  olast_q, olast_d;

  logic                  in_fire;
  logic                  in_ok;
  logic                  can_load;
  logic                  load;
  logic                  load_last;
  logic [CharWidth-1:0]  load_sym;
  logic [ValueWidth-1:0] in_value;
  step_t                 step;

  assign in_value      = s_axis_tdata[ValueWidth-1:0];
  assign s_axis_tready = (state_q == StIdle);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_ok         = (in_value != '0) && (in_value <= MaxValue);
  assign can_load      = !ovalid_q || m_axis_tready;

  // Shared compare/subtract unit on the current term.
  itrn_step_unit u_step (
    .term_i (term_q),
    .rest_i (rest_q),
    .res_o  (step)
  );

  // Sequencer: emit a second letter, emit a first letter, or move on.
  always_comb begin
    state_d   = state_q;
    term_d    = term_q;
    rest_d    = rest_q;
    pend_d    = pend_q;
    load      = 1'b0;
    load_last = 1'b0;
    load_sym  = step.first;
    case (state_q)
      StIdle: begin
        if (in_fire && in_ok) begin
          state_d = StBusy;
          term_d  = '0;
          rest_d  = in_value;
          pend_d  = 1'b0;
        end
      end
      StBusy: begin
        if (pend_q) begin
          if (can_load) begin
            load      = 1'b1;
            load_sym  = step.second;
            load_last = (rest_q == '0);
            pend_d    = 1'b0;
          end
        end else if (step.hit) begin
          if (can_load) begin
            load      = 1'b1;
            load_sym  = step.first;
            rest_d    = step.diff;
            pend_d    = step.has_second;
            load_last = !step.has_second && (step.diff == '0);
          end
        end else begin
          term_d = term_q + 1'b1;
        end
        if (load && load_last) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Output register: loads a letter or empties when taken.
  always_comb begin
    ovalid_d = ovalid_q;
    sym_d    = sym_q;
    olast_d  = olast_q;
    if (load) begin
      ovalid_d = 1'b1;
      sym_d    = load_sym;
      olast_d  = load_last;
    end else if (m_axis_tready) begin
      ovalid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      pend_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pend_q   <= pend_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    term_q  <= term_d;
    rest_q  <= rest_d;
    sym_q   <= sym_d;
    olast_q <= olast_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = sym_q;
  assign m_axis_tlast  = olast_q;

  // The term index stays inside the table while converting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StBusy) |-> (term_q <= LastTerm))
    else $error("term index ran past the table");

  // A pending second letter belongs to a subtractive pair.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StBusy && pend_q) |-> term_is_pair(term_q))
    else $error("second letter pending on a single-letter term");

  // Loading the final letter returns the converter to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && load_last) |=> (state_q == StIdle && m_axis_tvalid && m_axis_tlast))
    else $error("final letter did not end the conversion");

  // The remainder never exceeds the largest convertible number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StBusy) |-> (rest_q <= MaxValue))
    else $error("remainder out of range");

endmodule

/* sim/tb_integer_to_roman_numeral.sv */
// ----------------------------------------------------------------------------
// tb_integer_to_roman_numeral: self-checking bench for the numeral converter
// A short table of directed numbers, some with the numeral typed in, is
// followed by random numbers. A digit-by-digit model predicts the letter
// stream of each accepted number, and every output word is checked against
// the oldest predicted letter, including its tlast flag. Both stream sides
// idle at random, the receiver once holds off for a long stretch, and the
// sender pauses at times until every predicted letter has arrived.
// ----------------------------------------------------------------------------
module tb_integer_to_roman_numeral;
  import itrn_pkg::*;

  localparam int DirRows     = 24;
  localparam int RandomItems = 190;
  localparam int HoldCycles  = 400;
  localparam int IdleLimit   = 2000;
  localparam int DrainCycles = 40;
  localparam int ReportLimit = 10;
  localparam int PadWidth    = 16 - ValueWidth;

  // One predicted output word.
  typedef struct {
    logic [CharWidth-1:0] symbol;
    logic                 last;
  } letter_t;

  // Receiver stall patterns, each picked at random by the receiver process.
  typedef enum int unsigned {
    RxOpen,
    RxCoinFlip,
    RxEveryFourth,
    RxMostlyStalled
  } rx_mode_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // Fields from bit 0: value[11:0], zero padding.
  logic [15:0]           s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // Fields from bit 0: symbol[7:0].
  logic [7:0]            m_axis_tdata;
  logic                  m_axis_tlast;

  letter_t               letters_due[$];
  int unsigned           mismatches = 0;
  int unsigned           letters_seen = 0;
  int unsigned           hold_asks = 0;
  int unsigned           burst_left = 0;

  // Directed numbers; rows with dir_typed set carry their numeral by hand.
  logic [ValueWidth-1:0] dir_value [DirRows] = '{
    12'd1, 12'd2, 12'd3, 12'd4, 12'd5, 12'd9, 12'd10, 12'd40, 12'd50, 12'd90,
    12'd100, 12'd400, 12'd500, 12'd900, 12'd1000, 12'd3000, 12'd3888,
    12'd3999, 12'd0, 12'd4000, 12'd4095, 12'd1994, 12'd2730, 12'd1365
  };
  bit                    dir_typed [DirRows] = '{
    1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 0
  };
  string                 dir_numeral [DirRows] = '{
    "I", "II", "III", "IV", "V", "IX", "X", "XL", "L", "XC",
    "C", "CD", "D", "CM", "M", "MMM", "MMMDCCCLXXXVIII",
    "MMMCMXCIX", "", "", "", "", "", ""
  };

  integer_to_roman_numeral u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  // Letters of one decimal digit, given its one, five and ten letters.
  function automatic string digit_letters(input int d, input logic [CharWidth-1:0] one,
                                          input logic [CharWidth-1:0] five,
                                          input logic [CharWidth-1:0] ten);
    string s;
    s = "";
    if (d == 9) begin
      s = $sformatf("%c%c", one, ten);
    end else if (d == 4) begin
      s = $sformatf("%c%c", one, five);
    end else begin
      if (d >= 5) begin
        s = $sformatf("%c", five);
      end
      repeat (d % 5) s = $sformatf("%s%c", s, one);
    end
    return s;
  endfunction

  // Numeral of a number, or an empty string where none exists.
  function automatic string roman_of(input logic [ValueWidth-1:0] v);
    int n;
    n = int'(v);
    if (v == '0 || v > MaxValue) begin
      return "";
    end
    return {digit_letters(n / 1000, ChM, ChM, ChM),
            digit_letters((n / 100) % 10, ChC, ChD, ChM),
            digit_letters((n / 10) % 10, ChX, ChL, ChC),
            digit_letters(n % 10, ChI, ChV, ChX)};
  endfunction

  // Queue the letters of a numeral, flagging the final one.
  task automatic queue_numeral(input string numeral);
    letter_t w;
    for (int i = 0; i < numeral.len(); i++) begin
      w.symbol = numeral[i];
      w.last   = (i == numeral.len() - 1);
      letters_due.push_back(w);
    end
  endtask

  // Random numbers, some zero or above 3999; a share favours the digits 3, 4, 8 and 9.
  function automatic logic [ValueWidth-1:0] pick_value();
    int unsigned roll;
    int unsigned n;
    int unsigned heavy [4] = '{3, 4, 8, 9};
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      return '0;
    end
    if (roll < 9) begin
      return ValueWidth'($urandom_range(4000, 4095));
    end
    if (roll < 40) begin
      n = $urandom_range(0, 3) * 1000;
      n += ($urandom_range(0, 1) ? heavy[$urandom_range(0, 3)] : $urandom_range(0, 9)) * 100;
      n += ($urandom_range(0, 1) ? heavy[$urandom_range(0, 3)] : $urandom_range(0, 9)) * 10;
      n += ($urandom_range(0, 1) ? heavy[$urandom_range(0, 3)] : $urandom_range(0, 9));
      return (n == 0) ? 12'd3888 : ValueWidth'(n);
    end
    return ValueWidth'($urandom_range(1, 3999));
  endfunction

  // Offer one number and hold it until the converter takes the word.
  task automatic send_number(input logic [ValueWidth-1:0] v);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{PadWidth{1'b0}}, v};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Burst bookkeeping: at the end of a burst the sender may idle for a while.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 :
            ($urandom_range(0, 4) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  // Stop offering and wait until every predicted letter has arrived.
  task automatic drain_letters();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (letters_due.size() != 0) @(posedge clk_i);
  endtask

  // Stimulus: directed table, then random numbers, then the final check.
  initial begin
    logic [ValueWidth-1:0] v;
    int unsigned           taken;
    taken = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DirRows; i++) begin
      send_number(dir_value[i]);
      queue_numeral(dir_typed[i] ? dir_numeral[i] : roman_of(dir_value[i]));
      pace_sender();
    end
    drain_letters();

    while (taken < RandomItems) begin
      v = pick_value();
      send_number(v);
      queue_numeral(roman_of(v));
      if (v != '0 && v <= MaxValue) begin
        taken++;
        // Long receiver hold-off while the sender keeps offering.
        if (taken == 70) begin
          hold_asks++;
        end
        if (taken == 140) begin
          drain_letters();
        end
      end
      pace_sender();
    end

    drain_letters();
    repeat (DrainCycles) @(posedge clk_i);
    if (letters_due.size() != 0) begin
      mismatches++;
      $display("%0d predicted letters never arrived", letters_due.size());
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Receiver: rotating stall patterns, plus a long hold-off on request.
  always @(negedge clk_i) begin : receiver
    static int unsigned rx_cycle  = 0;
    static int unsigned hold_seen = 0;
    static int unsigned hold_left = 0;
    static rx_mode_e    rx_mode   = RxOpen;
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_cycle % 48 == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
      end
      case (rx_mode)
        RxOpen:        m_axis_tready <= 1'b1;
        RxCoinFlip:    m_axis_tready <= ($urandom_range(0, 1) == 1);
        RxEveryFourth: m_axis_tready <= (rx_cycle % 4) != 3;
        default:       m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
      rx_cycle++;
    end
  end

  // Output check: each accepted word against the oldest predicted letter.
  always @(posedge clk_i) begin : letter_check
    letter_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      letters_seen++;
      if (letters_due.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display("word %0d: unexpected letter %c last=%0b", letters_seen,
                   m_axis_tdata, m_axis_tlast);
        end
      end else begin
        want = letters_due.pop_front();
        if (m_axis_tdata !== want.symbol || m_axis_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= ReportLimit) begin
            $display("word %0d: expected %c last=%0b, got %c (%h) last=%0b",
                     letters_seen, want.symbol, want.last, m_axis_tdata,
                     m_axis_tdata, m_axis_tlast);
          end
        end
      end
    end
  end

  // Watchdog: too many cycles without a word moving on either side.
  always @(posedge clk_i) begin : watchdog
    static int unsigned quiet = 0;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet == IdleLimit) begin
      $display("no word moved for %0d cycles", IdleLimit);
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
